// ===== rtl/vfc_pkg.sv =====
// Shared types, constants and helper functions for the voxel face cull / quad emit block.
package vfc_pkg;

    // Fixed field widths
    localparam int SIZE_BITS    = 9;
    localparam int ID_BITS      = 8;
    localparam int NB_BITS      = 48;
    localparam int LH_BITS      = 40;
    localparam int LH_LANE_BITS = 8;
    localparam int TEX_BITS     = 64;
    localparam int SHADE_BITS   = 16;
    localparam int MODE_BITS    = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int NUM_FACES    = 8;
    localparam int NUM_CUBE_FACES = 6;
    localparam int Q_DEPTH      = 2;

    // Parameter defaults
    localparam int DEF_COORD_BITS = 8;
    localparam int DEF_UV_BITS    = 16;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd64;

    // Block modes
    localparam logic [MODE_BITS-1:0] MODE_CUBE   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LIQUID = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CROSS  = 2'd2;

    // Config register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z = 2'd2;

    // Face codes: z+1, z-1, x+1, x-1, top, bottom, then two diagonals
    localparam logic [2:0] FACE_ZP    = 3'd0;
    localparam logic [2:0] FACE_ZN    = 3'd1;
    localparam logic [2:0] FACE_XP    = 3'd2;
    localparam logic [2:0] FACE_XN    = 3'd3;
    localparam logic [2:0] FACE_TOP   = 3'd4;
    localparam logic [2:0] FACE_BOT   = 3'd5;
    localparam logic [2:0] FACE_DIAG0 = 3'd6;
    localparam logic [2:0] FACE_DIAG1 = 3'd7;

    // Vertex colors
    localparam logic [SHADE_BITS-1:0] SHADE_Z_DARK  = 16'h888F;
    localparam logic [SHADE_BITS-1:0] SHADE_Z_LIT   = 16'hCCCF;
    localparam logic [SHADE_BITS-1:0] SHADE_X_DARK  = 16'h777F;
    localparam logic [SHADE_BITS-1:0] SHADE_X_LIT   = 16'h999F;
    localparam logic [SHADE_BITS-1:0] SHADE_TOP_DARK = 16'h999F;
    localparam logic [SHADE_BITS-1:0] SHADE_TOP_LIT  = 16'hFFFF;
    localparam logic [SHADE_BITS-1:0] SHADE_BOT     = 16'h555F;

    // Transparent ids
    localparam logic [ID_BITS-1:0] ID_AIR     = 8'd0;
    localparam logic [ID_BITS-1:0] ID_SAPLING = 8'd6;
    localparam logic [ID_BITS-1:0] ID_WATER   = 8'd8;
    localparam logic [ID_BITS-1:0] ID_LEAVES  = 8'd18;
    localparam logic [ID_BITS-1:0] ID_GLASS   = 8'd20;
    localparam logic [ID_BITS-1:0] ID_PLANT_LO = 8'd37;
    localparam logic [ID_BITS-1:0] ID_PLANT_HI = 8'd40;

    // Corner offsets {dx,dy,dz} per face and vertex
    localparam logic [2:0] CORNER [0:NUM_FACES-1][0:3] = '{
        '{3'b011, 3'b111, 3'b101, 3'b001},
        '{3'b110, 3'b010, 3'b000, 3'b100},
        '{3'b111, 3'b110, 3'b100, 3'b101},
        '{3'b010, 3'b011, 3'b001, 3'b000},
        '{3'b010, 3'b110, 3'b111, 3'b011},
        '{3'b100, 3'b000, 3'b001, 3'b101},
        '{3'b010, 3'b111, 3'b101, 3'b000},
        '{3'b011, 3'b110, 3'b100, 3'b001}
    };

    // Classification of one block, passed front to back
    typedef struct packed {
        logic [NUM_FACES-1:0]      face_mask;  // faces to draw
        logic [NUM_CUBE_FACES-2:0] dark;       // shadow flag per face, [4] top/diagonals
        logic                      multi_tex;  // top/bottom use own texture
    } t_cls;

    function automatic logic see_through(input logic [ID_BITS-1:0] self_id,
                                         input logic [ID_BITS-1:0] nb_id);
        logic hit;
        hit = (nb_id == ID_AIR) || (nb_id == ID_SAPLING) || (nb_id == ID_WATER) ||
              (nb_id == ID_LEAVES) || (nb_id == ID_GLASS) ||
              ((nb_id >= ID_PLANT_LO) && (nb_id <= ID_PLANT_HI));
        return hit && (nb_id != self_id);
    endfunction

    function automatic logic [SHADE_BITS-1:0] shade_of(input logic [2:0] face,
                                                       input logic [NUM_CUBE_FACES-2:0] dark);
        logic [SHADE_BITS-1:0] s;
        unique case (face)
            FACE_ZP:    s = dark[0] ? SHADE_Z_DARK : SHADE_Z_LIT;
            FACE_ZN:    s = dark[1] ? SHADE_Z_DARK : SHADE_Z_LIT;
            FACE_XP:    s = dark[2] ? SHADE_X_DARK : SHADE_X_LIT;
            FACE_XN:    s = dark[3] ? SHADE_X_DARK : SHADE_X_LIT;
            FACE_BOT:   s = SHADE_BOT;
            FACE_TOP, FACE_DIAG0, FACE_DIAG1:
                        s = dark[4] ? SHADE_TOP_DARK : SHADE_TOP_LIT;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/vfc_front.sv =====
// Front stage: accepts a block beat, runs the face visibility and shadow tests, registers the result.
module vfc_front import vfc_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [MODE_BITS-1:0]  i_mode,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [COORD_BITS-1:0] i_pos_z,
    input  logic [ID_BITS-1:0]    i_block_id,
    input  logic [NB_BITS-1:0]    i_neighbor_ids,
    input  logic [LH_BITS-1:0]    i_light_heights,
    input  logic [TEX_BITS-1:0]   i_tex_top,
    input  logic [TEX_BITS-1:0]   i_tex_side,
    input  logic [TEX_BITS-1:0]   i_tex_bottom,
    input  logic [SIZE_BITS-1:0]  i_size_x,
    input  logic [SIZE_BITS-1:0]  i_size_y,
    input  logic [SIZE_BITS-1:0]  i_size_z,
    output logic                  o_push,
    input  logic                  i_q_ready,
    output t_cls                  o_cls,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y,
    output logic [COORD_BITS-1:0] o_pos_z,
    output logic [TEX_BITS-1:0]   o_tex_top,
    output logic [TEX_BITS-1:0]   o_tex_side,
    output logic [TEX_BITS-1:0]   o_tex_bottom
);
    // border compare width and light compare width
    localparam int SW = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
    localparam int LW = (COORD_BITS > LH_LANE_BITS) ? COORD_BITS : LH_LANE_BITS;

    logic                  r_valid;
    t_cls                  r_cls;
    logic [COORD_BITS-1:0] r_pos_x, r_pos_y, r_pos_z;
    logic [TEX_BITS-1:0]   r_tex_top, r_tex_side, r_tex_bottom;

    logic [ID_BITS-1:0]      nb [NUM_CUBE_FACES];
    logic [LW-1:0]           lh [NUM_CUBE_FACES-1];
    logic                    far_x, far_y, far_z, near_x, near_y, near_z;
    logic [NUM_CUBE_FACES-1:0] vis;
    logic [NUM_CUBE_FACES-2:0] dark;
    t_cls                    n_cls;
    logic                    has_faces;
    logic                    load;

    always_comb begin
        for (int f = 0; f < NUM_CUBE_FACES; f++) begin
            nb[f] = i_neighbor_ids[f*ID_BITS +: ID_BITS];
        end
        for (int h = 0; h < NUM_CUBE_FACES - 1; h++) begin
            lh[h] = LW'(i_light_heights[h*LH_LANE_BITS +: LH_LANE_BITS]);
        end
    end

    // pos >= size-1 written as pos+1 >= size; size 0 makes every position a border
    assign far_x  = (SW'(i_pos_x) + SW'(1)) >= SW'(i_size_x);
    assign far_y  = (SW'(i_pos_y) + SW'(1)) >= SW'(i_size_y);
    assign far_z  = (SW'(i_pos_z) + SW'(1)) >= SW'(i_size_z);
    assign near_x = (i_pos_x == '0);
    assign near_y = (i_pos_y == '0);
    assign near_z = (i_pos_z == '0);

    always_comb begin
        vis[0] = far_z  || see_through(i_block_id, nb[0]);
        vis[1] = near_z || see_through(i_block_id, nb[1]);
        vis[2] = far_x  || see_through(i_block_id, nb[2]);
        vis[3] = near_x || see_through(i_block_id, nb[3]);
        vis[4] = far_y  || ((i_mode == MODE_LIQUID) ? (i_block_id != nb[4])
                                                     : see_through(i_block_id, nb[4]));
        vis[5] = !near_y && see_through(i_block_id, nb[5]);

        dark[0] = !far_z  && (lh[1] > LW'(i_pos_y));
        dark[1] = !near_z && (lh[2] > LW'(i_pos_y));
        dark[2] = !far_x  && (lh[3] > LW'(i_pos_y));
        dark[3] = !near_x && (lh[4] > LW'(i_pos_y));
        dark[4] = lh[0] > LW'(i_pos_y);

        n_cls.dark      = dark;
        n_cls.multi_tex = (i_mode == MODE_CUBE);
        unique case (i_mode)
            MODE_CUBE, MODE_LIQUID: n_cls.face_mask = {2'b00, vis};
            MODE_CROSS:             n_cls.face_mask = 8'b1100_0000;
            default:                n_cls.face_mask = '0;
        endcase
    end

    // a beat with nothing to draw is dropped here and never queued
    assign has_faces = |r_cls.face_mask;
    assign o_push    = r_valid && has_faces;
    assign o_ready   = !r_valid || !has_faces || i_q_ready;
    assign load      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cls        <= n_cls;
            r_pos_x      <= i_pos_x;
            r_pos_y      <= i_pos_y;
            r_pos_z      <= i_pos_z;
            r_tex_top    <= i_tex_top;
            r_tex_side   <= i_tex_side;
            r_tex_bottom <= i_tex_bottom;
        end
    end

    assign o_cls        = r_cls;
    assign o_pos_x      = r_pos_x;
    assign o_pos_y      = r_pos_y;
    assign o_pos_z      = r_pos_z;
    assign o_tex_top    = r_tex_top;
    assign o_tex_side   = r_tex_side;
    assign o_tex_bottom = r_tex_bottom;

endmodule

// ===== rtl/vfc_fifo.sv =====
// Small register FIFO that decouples the classify front from the vertex emit back.
module vfc_fifo import vfc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/vfc_back.sv =====
// Back stage: walks the visible faces of the queue head and emits four vertices per face.
module vfc_back import vfc_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int UV_BITS    = DEF_UV_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_pop,
    input  t_cls                  i_cls,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [COORD_BITS-1:0] i_pos_z,
    input  logic [TEX_BITS-1:0]   i_tex_top,
    input  logic [TEX_BITS-1:0]   i_tex_side,
    input  logic [TEX_BITS-1:0]   i_tex_bottom,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS:0]   o_vert_x,
    output logic [COORD_BITS:0]   o_vert_y,
    output logic [COORD_BITS:0]   o_vert_z,
    output logic [SHADE_BITS-1:0] o_shade,
    output logic [UV_BITS-1:0]    o_tex_u,
    output logic [UV_BITS-1:0]    o_tex_v,
    output logic                  o_last
);
    localparam int EW = TEX_BITS + 4 * UV_BITS;

    logic [NUM_FACES-1:0] r_done;
    logic [1:0]           r_k;
    logic                 r_out_valid;
    logic [COORD_BITS:0]  r_vx, r_vy, r_vz;
    logic [SHADE_BITS-1:0] r_shade;
    logic [UV_BITS-1:0]   r_u, r_v;
    logic                 r_last;

    logic [NUM_FACES-1:0] rem, rem_after;
    logic [2:0]           face;
    logic [2:0]           crn;
    logic [TEX_BITS-1:0]  tex;
    logic [EW-1:0]        tex_ext;
    logic [UV_BITS-1:0]   uv0, uv1, uv2, uv3;
    logic                 step, face_end, item_end;

    assign rem = i_cls.face_mask & ~r_done;

    // lowest remaining face goes first
    always_comb begin
        face = '0;
        for (int f = NUM_FACES - 1; f >= 0; f--) begin
            if (rem[f]) begin
                face = 3'(f);
            end
        end
    end

    assign rem_after = rem & ~(NUM_FACES'(1) << face);
    assign face_end  = (r_k == 2'd3);
    assign item_end  = face_end && (rem_after == '0);
    assign step      = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_pop     = step && item_end;

    always_comb begin
        if (i_cls.multi_tex && (face == FACE_TOP)) begin
            tex = i_tex_top;
        end else if (i_cls.multi_tex && (face == FACE_BOT)) begin
            tex = i_tex_bottom;
        end else begin
            tex = i_tex_side;
        end
    end

    // lanes past the 64-bit word read as zero
    assign tex_ext = {{(4*UV_BITS){1'b0}}, tex};
    assign uv0 = tex_ext[0*UV_BITS +: UV_BITS];
    assign uv1 = tex_ext[1*UV_BITS +: UV_BITS];
    assign uv2 = tex_ext[2*UV_BITS +: UV_BITS];
    assign uv3 = tex_ext[3*UV_BITS +: UV_BITS];

    assign crn = CORNER[face][r_k];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_out_valid <= 1'b1;
                r_k         <= r_k + 2'd1;
                if (item_end) begin
                    r_done <= '0;
                end else if (face_end) begin
                    r_done <= r_done | (NUM_FACES'(1) << face);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_vx    <= {1'b0, i_pos_x} + (COORD_BITS+1)'(crn[2]);
            r_vy    <= {1'b0, i_pos_y} + (COORD_BITS+1)'(crn[1]);
            r_vz    <= {1'b0, i_pos_z} + (COORD_BITS+1)'(crn[0]);
            r_shade <= shade_of(face, i_cls.dark);
            r_u     <= ((r_k == 2'd1) || (r_k == 2'd2)) ? uv2 : uv0;
            r_v     <= r_k[1] ? uv3 : uv1;
            r_last  <= item_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_vert_x    = r_vx;
    assign o_vert_y    = r_vy;
    assign o_vert_z    = r_vz;
    assign o_shade     = r_shade;
    assign o_tex_u     = r_u;
    assign o_tex_v     = r_v;
    assign o_last      = r_last;

endmodule

// ===== rtl/voxel_face_cull_quad_emit.sv =====
// Top level of the voxel face cull / quad emit block: config registers, front, queue and back.
//
// One beat in describes a block to draw; the block answers with four vertex beats for every
// visible face (up to 24 for a cube, always 8 for crossed plants, none for mode 3 or a fully
// hidden cube), o_last marking the final vertex of the block. The emit side produces one vertex
// per cycle while the queue holds a block and i_out_ready allows. The front classifies a block
// and registers the result, and a two-entry queue sits between front and back, so new blocks
// keep being taken while the queue has room, even while the back is still emitting and while
// a finished vertex waits for i_out_ready; a block that draws nothing never reaches the queue.
// The first vertex passes the front register, then the queue write, then the output register
// before it is on the outputs. The user must write world sizes through the config channel
// (always ready) only while idle; the block itself does not enforce it.
module voxel_face_cull_quad_emit import vfc_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int UV_BITS    = DEF_UV_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // block beats
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [MODE_BITS-1:0]    i_mode,
    input  logic [COORD_BITS-1:0]   i_pos_x,
    input  logic [COORD_BITS-1:0]   i_pos_y,
    input  logic [COORD_BITS-1:0]   i_pos_z,
    input  logic [ID_BITS-1:0]      i_block_id,
    input  logic [NB_BITS-1:0]      i_neighbor_ids,
    input  logic [LH_BITS-1:0]      i_light_heights,
    input  logic [TEX_BITS-1:0]     i_tex_top,
    input  logic [TEX_BITS-1:0]     i_tex_side,
    input  logic [TEX_BITS-1:0]     i_tex_bottom,
    // vertex beats
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [COORD_BITS:0]     o_vert_x,
    output logic [COORD_BITS:0]     o_vert_y,
    output logic [COORD_BITS:0]     o_vert_z,
    output logic [SHADE_BITS-1:0]   o_shade,
    output logic [UV_BITS-1:0]      o_tex_u,
    output logic [UV_BITS-1:0]      o_tex_v,
    output logic                    o_last,
    // config writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [SIZE_BITS-1:0]    i_cfg_data
);
    // queue entry: classification, position, three texture words
    localparam int QW = $bits(t_cls) + 3 * COORD_BITS + 3 * TEX_BITS;

    logic [SIZE_BITS-1:0] r_size_x, r_size_y, r_size_z;

    t_cls                  f_cls, q_cls;
    logic [COORD_BITS-1:0] f_pos_x, f_pos_y, f_pos_z;
    logic [COORD_BITS-1:0] q_pos_x, q_pos_y, q_pos_z;
    logic [TEX_BITS-1:0]   f_tex_top, f_tex_side, f_tex_bottom;
    logic [TEX_BITS-1:0]   q_tex_top, q_tex_side, q_tex_bottom;
    logic                  f_push, q_ready, q_valid, q_pop;
    logic [QW-1:0]         q_wdata, q_rdata;

    // config registers; writes to an unused index are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_RESET;
            r_size_y <= SIZE_RESET;
            r_size_z <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SIZE_X: r_size_x <= i_cfg_data;
                REG_SIZE_Y: r_size_y <= i_cfg_data;
                REG_SIZE_Z: r_size_z <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    vfc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_block_id     (i_block_id),
        .i_neighbor_ids (i_neighbor_ids),
        .i_light_heights(i_light_heights),
        .i_tex_top      (i_tex_top),
        .i_tex_side     (i_tex_side),
        .i_tex_bottom   (i_tex_bottom),
        .i_size_x       (r_size_x),
        .i_size_y       (r_size_y),
        .i_size_z       (r_size_z),
        .o_push         (f_push),
        .i_q_ready      (q_ready),
        .o_cls          (f_cls),
        .o_pos_x        (f_pos_x),
        .o_pos_y        (f_pos_y),
        .o_pos_z        (f_pos_z),
        .o_tex_top      (f_tex_top),
        .o_tex_side     (f_tex_side),
        .o_tex_bottom   (f_tex_bottom)
    );

    assign q_wdata = {f_cls, f_pos_x, f_pos_y, f_pos_z, f_tex_top, f_tex_side, f_tex_bottom};

    vfc_fifo #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_ready (q_ready),
        .i_data  (q_wdata),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    assign {q_cls, q_pos_x, q_pos_y, q_pos_z, q_tex_top, q_tex_side, q_tex_bottom} = q_rdata;

    vfc_back #(
        .COORD_BITS (COORD_BITS),
        .UV_BITS    (UV_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .o_pop        (q_pop),
        .i_cls        (q_cls),
        .i_pos_x      (q_pos_x),
        .i_pos_y      (q_pos_y),
        .i_pos_z      (q_pos_z),
        .i_tex_top    (q_tex_top),
        .i_tex_side   (q_tex_side),
        .i_tex_bottom (q_tex_bottom),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_vert_x     (o_vert_x),
        .o_vert_y     (o_vert_y),
        .o_vert_z     (o_vert_z),
        .o_shade      (o_shade),
        .o_tex_u      (o_tex_u),
        .o_tex_v      (o_tex_v),
        .o_last       (o_last)
    );

endmodule

// ===== rtl/vfc_checker.sv =====
// Port-level checker for the voxel face cull / quad emit block, bound to the top level.
module vfc_checker import vfc_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int UV_BITS    = DEF_UV_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  logic [COORD_BITS:0]     o_vert_x,
    input  logic [COORD_BITS:0]     o_vert_y,
    input  logic [COORD_BITS:0]     o_vert_z,
    input  logic [SHADE_BITS-1:0]   o_shade,
    input  logic [UV_BITS-1:0]      o_tex_u,
    input  logic [UV_BITS-1:0]      o_tex_v,
    input  logic                    o_last
);
    // vertex beat count within a quad
    logic [1:0] r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    // a stalled vertex beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_vert_x) &&
        $stable(o_vert_y) && $stable(o_vert_z) && $stable(o_shade) &&
        $stable(o_tex_u) && $stable(o_tex_v) && $stable(o_last))
        else $error("vertex beat changed while stalled");

    // a block always ends on the fourth vertex of a quad
    a_last_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> r_beat == 2'd3)
        else $error("last flag not on a quad boundary");

    // shade is always one of the face colors
    a_shade_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_shade == SHADE_Z_DARK) || (o_shade == SHADE_Z_LIT) ||
        (o_shade == SHADE_X_DARK) || (o_shade == SHADE_X_LIT) ||
        (o_shade == SHADE_TOP_LIT) || (o_shade == SHADE_BOT))
        else $error("shade outside face color set");

    // no vertex beat in the cycle after a reset cycle
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("vertex beat right after reset");

endmodule

bind voxel_face_cull_quad_emit vfc_checker #(
    .COORD_BITS (COORD_BITS),
    .UV_BITS    (UV_BITS)
) u_vfc_checker (.*);
